// File: src/bcg_pkg.sv
// Shared types and constants for the battery charge gauge.
package bcg_pkg;

  localparam int DIV_DW    = 32;            // dividend / quotient width
  localparam int DIV_VW    = 20;            // divisor width (36 * capacity fits)
  localparam int DIV_STEPS = DIV_DW / 2;    // two quotient bits per cycle
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [2:0] REG_CAPACITY = 3'd0;
  localparam logic [2:0] REG_EOD_MV   = 3'd1;
  localparam logic [2:0] REG_EOC_MV   = 3'd2;
  localparam logic [2:0] REG_MAX_MA   = 3'd3;
  localparam logic [2:0] REG_FALLOFF  = 3'd4;

  localparam logic [13:0] RST_CAPACITY = 14'd2000;
  localparam logic [15:0] RST_EOD_MV   = 16'd3000;
  localparam logic [15:0] RST_EOC_MV   = 16'd4200;
  localparam logic [14:0] RST_MAX_MA   = 15'd1000;
  localparam logic [15:0] RST_FALLOFF  = 16'd200;
  localparam logic [31:0] RST_CHARGE   = 32'd3600000;

  localparam logic [19:0] REQ_ZERO_PCT = 20'd20;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

endpackage

// File: src/bcg_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
module bcg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bcg_pkg::div_req_t req,
  output bcg_pkg::div_rsp_t rsp
);
  import bcg_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] dq_r;     // dividend bits shift out the top, quotient bits in the bottom
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] dvs_r;

  logic [DIV_VW:0]   r1, r2, d1, d2;
  logic              ge1, ge2;
  logic [DIV_VW-1:0] m1, m2;

  always_comb begin
    r1  = {rem_r, dq_r[DIV_DW-1]};
    ge1 = r1 >= {1'b0, dvs_r};
    d1  = r1 - {1'b0, dvs_r};
    m1  = ge1 ? d1[DIV_VW-1:0] : r1[DIV_VW-1:0];
    r2  = {m1, dq_r[DIV_DW-2]};
    ge2 = r2 >= {1'b0, dvs_r};
    d2  = r2 - {1'b0, dvs_r};
    m2  = ge2 ? d2[DIV_VW-1:0] : r2[DIV_VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[DIV_DW-3:0], ge1, ge2};
      rem_r <= m2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

endmodule

// File: src/battery_charge_gauge.sv
// Coulomb-counting fuel gauge: config registers, tick sequencer and result register.
// Each tick makes one to four passes through the shared 2-bit-per-cycle divider.
// A new input transfer is taken only once the previous result is in the output register,
//   even while that result waits.
// Reset (synchronous, rst_n low): registers to defaults, charge to 3600000 mC, marks cleared.
module battery_charge_gauge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [20:0] charge_delta_mc, [36:21] batt_voltage_mv, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [15:0] soc_pct, [16] eod_flag, [17] eoc_flag,
                                  // [33:18] charge_req_ma, [48:34] max_charge_ma,
                                  // [63:49] max_discharge_ma
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import bcg_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_UPD      = 4'd1;
  localparam logic [3:0] ST_SOC_GO   = 4'd2;
  localparam logic [3:0] ST_SOC_WAIT = 4'd3;
  localparam logic [3:0] ST_REQ_MUL  = 4'd4;
  localparam logic [3:0] ST_REQ_GO   = 4'd5;
  localparam logic [3:0] ST_REQ_WAIT = 4'd6;
  localparam logic [3:0] ST_CHG      = 4'd7;
  localparam logic [3:0] ST_CHG_GO   = 4'd8;
  localparam logic [3:0] ST_CHG_WAIT = 4'd9;
  localparam logic [3:0] ST_DIS      = 4'd10;
  localparam logic [3:0] ST_DIS_GO   = 4'd11;
  localparam logic [3:0] ST_DIS_WAIT = 4'd12;
  localparam logic [3:0] ST_OUT      = 4'd13;

  // configuration
  logic [13:0] cap_r;
  logic [15:0] eod_r, eoc_r, fall_r;
  logic [14:0] max_r;

  // control state
  logic [3:0]  state_r, state_nxt;
  logic [31:0] charge_r, charge_nxt;
  logic        eod_mark_r, eod_mark_nxt, eoc_mark_r, eoc_mark_nxt;
  logic        out_valid_r, out_valid_nxt;

  // working registers
  logic signed [20:0] delta_r;
  logic [15:0] v_r;
  logic [15:0] soc_r, soc_nxt;
  logic [15:0] req_r, req_nxt;
  logic [14:0] mch_r, mch_nxt, mdis_r, mdis_nxt;
  logic [30:0] prod_r, prod_nxt;
  logic [63:0] out_data_r, out_data_nxt;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [32:0] sum_w;
  logic [31:0] sat_w;
  logic [31:0] cap_ext, cap3600;
  logic [19:0] cap36;
  logic [31:0] charge_mag;
  logic [15:0] soc_mag;
  logic [15:0] mul_a;
  logic [33:0] req_sum;
  logic [31:0] q_neg;

  bcg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= RST_CAPACITY;
      eod_r  <= RST_EOD_MV;
      eoc_r  <= RST_EOC_MV;
      max_r  <= RST_MAX_MA;
      fall_r <= RST_FALLOFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAPACITY: cap_r  <= cfg_wdata[13:0];
        REG_EOD_MV:   eod_r  <= cfg_wdata;
        REG_EOC_MV:   eoc_r  <= cfg_wdata;
        REG_MAX_MA:   max_r  <= cfg_wdata[14:0];
        REG_FALLOFF:  fall_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_w   = {charge_r[31], charge_r} + {{12{delta_r[20]}}, delta_r};
    if (sum_w[32] != sum_w[31])
      sat_w = sum_w[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else
      sat_w = sum_w[31:0];
    cap_ext    = {18'b0, cap_r};
    cap3600    = (cap_ext << 12) - (cap_ext << 9) + (cap_ext << 4);
    cap36      = ({6'b0, cap_r} << 5) + ({6'b0, cap_r} << 2);
    charge_mag = charge_r[31] ? (32'd0 - charge_r) : charge_r;
    soc_mag    = soc_r[15] ? (16'd0 - soc_r) : soc_r;
    q_neg      = 32'd0 - div_rsp.quot;
    req_sum    = soc_r[15] ? ({19'b0, max_r} + {2'b0, div_rsp.quot})
                           : ({19'b0, max_r} - {2'b0, div_rsp.quot});
  end

  // shared multiplier operand
  always_comb begin
    unique case (state_r)
      ST_CHG:  mul_a = eoc_r - v_r;
      ST_DIS:  mul_a = v_r - eod_r;
      default: mul_a = soc_mag;
    endcase
  end

  always_comb begin
    div_req.start    = (state_r == ST_SOC_GO && cap_r != '0) || state_r == ST_REQ_GO ||
                       state_r == ST_CHG_GO || state_r == ST_DIS_GO;
    div_req.dividend = (state_r == ST_SOC_GO) ? charge_mag : {1'b0, prod_r};
    unique case (state_r)
      ST_SOC_GO: div_req.divisor = cap36;
      ST_REQ_GO: div_req.divisor = REQ_ZERO_PCT;
      default:   div_req.divisor = {4'b0, fall_r};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    charge_nxt    = charge_r;
    eod_mark_nxt  = eod_mark_r;
    eoc_mark_nxt  = eoc_mark_r;
    out_valid_nxt = out_valid_r && !out_tready;
    soc_nxt       = soc_r;
    req_nxt       = req_r;
    mch_nxt       = mch_r;
    mdis_nxt      = mdis_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_UPD;
      ST_UPD: begin
        if (v_r <= eod_r) begin
          charge_nxt   = '0;
          eod_mark_nxt = 1'b1;
        end else if (v_r >= eoc_r) begin
          charge_nxt   = cap3600;
          eoc_mark_nxt = 1'b1;
        end else begin
          charge_nxt   = sat_w;
          eod_mark_nxt = 1'b0;
          eoc_mark_nxt = 1'b0;
        end
        state_nxt = ST_SOC_GO;
      end
      ST_SOC_GO: begin
        // zero capacity reads as empty
        if (cap_r == '0) begin
          soc_nxt   = '0;
          state_nxt = ST_REQ_MUL;
        end else begin
          state_nxt = ST_SOC_WAIT;
        end
      end
      ST_SOC_WAIT: if (div_rsp.done) begin
        if (charge_r[31])
          soc_nxt = (div_rsp.quot > 32'd32768) ? 16'h8000 : q_neg[15:0];
        else
          soc_nxt = (div_rsp.quot > 32'd32767) ? 16'h7FFF : div_rsp.quot[15:0];
        state_nxt = ST_REQ_MUL;
      end
      ST_REQ_MUL: begin
        prod_nxt  = {15'b0, mul_a} * {16'b0, max_r};
        state_nxt = ST_REQ_GO;
      end
      ST_REQ_GO: state_nxt = ST_REQ_WAIT;
      ST_REQ_WAIT: if (div_rsp.done) begin
        if (req_sum[33])
          req_nxt = '0;
        else if (|req_sum[32:16])
          req_nxt = 16'hFFFF;
        else
          req_nxt = req_sum[15:0];
        state_nxt = ST_CHG;
      end
      ST_CHG: begin
        if (v_r >= eoc_r || eoc_mark_r) begin
          mch_nxt   = '0;
          state_nxt = ST_DIS;
        end else if ({1'b0, v_r} + {1'b0, fall_r} <= {1'b0, eoc_r}) begin
          mch_nxt   = max_r;
          state_nxt = ST_DIS;
        end else begin
          prod_nxt  = {15'b0, mul_a} * {16'b0, max_r};
          state_nxt = ST_CHG_GO;
        end
      end
      ST_CHG_GO: state_nxt = ST_CHG_WAIT;
      ST_CHG_WAIT: if (div_rsp.done) begin
        mch_nxt   = div_rsp.quot[14:0];
        state_nxt = ST_DIS;
      end
      ST_DIS: begin
        if (v_r <= eod_r || eod_mark_r) begin
          mdis_nxt  = '0;
          state_nxt = ST_OUT;
        end else if ({1'b0, v_r} >= {1'b0, eod_r} + {1'b0, fall_r}) begin
          mdis_nxt  = max_r;
          state_nxt = ST_OUT;
        end else begin
          prod_nxt  = {15'b0, mul_a} * {16'b0, max_r};
          state_nxt = ST_DIS_GO;
        end
      end
      ST_DIS_GO: state_nxt = ST_DIS_WAIT;
      ST_DIS_WAIT: if (div_rsp.done) begin
        mdis_nxt  = div_rsp.quot[14:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_valid_r || out_tready) begin
        out_data_nxt  = {mdis_r, mch_r, req_r, eoc_mark_r, eod_mark_r, soc_r};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      charge_r    <= RST_CHARGE;
      eod_mark_r  <= 1'b0;
      eoc_mark_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      charge_r    <= charge_nxt;
      eod_mark_r  <= eod_mark_nxt;
      eoc_mark_r  <= eoc_mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      delta_r <= in_tdata[20:0];
      v_r     <= in_tdata[36:21];
    end
    soc_r      <= soc_nxt;
    req_r      <= req_nxt;
    mch_r      <= mch_nxt;
    mdis_r     <= mdis_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: verif/battery_charge_gauge_test.sv
// Self-checking testbench for battery_charge_gauge: directed table, random ticks, stream checks.
module battery_charge_gauge_test;
  import bcg_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int SETTLE_CYCLES = 100;    // longer than the worst tick latency
  localparam int HOLD_CYCLES = 600;
  localparam int REPORT_CAP = 100;
  localparam longint SEC_PER_HOUR = 3600;
  localparam longint MC_PER_PCT_MAH = 36;
  localparam longint REQ_ZERO_SOC = 20;
  localparam longint CHG_MAX = 64'sd2147483647;
  localparam longint CHG_MIN = -64'sd2147483648;
  localparam logic [2:0] REG_SPARE = 3'd5;    // indexes above falloff are ignored
  localparam logic [2:0] REG_SPARE_TOP = 3'd7;

  typedef struct packed {
    logic [2:0]         pad;
    logic [15:0]        batt_voltage_mv;
    logic signed [20:0] charge_delta_mc;
  } tick_t;

  typedef struct packed {
    logic [14:0]        max_discharge_ma;
    logic [14:0]        max_charge_ma;
    logic [15:0]        charge_req_ma;
    logic               eoc_flag;
    logic               eod_flag;
    logic signed [15:0] soc_pct;
  } reading_t;

  typedef struct {
    bit       known;
    reading_t val;
  } typed_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [2:0]         addr;
    logic [15:0]        wdata;
    logic signed [20:0] delta;
    logic [15:0]        volt;
    bit                 known;
    reading_t           val;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [20:0] charge_delta_mc, [36:21] batt_voltage_mv, rest zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;  // [15:0] soc_pct, [16] eod_flag, [17] eoc_flag,
                           // [33:18] charge_req_ma, [48:34] max_charge_ma,
                           // [63:49] max_discharge_ma
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  battery_charge_gauge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // gauge state and register copies
  logic [13:0] cap_mah = 14'd2000;
  logic [15:0] eod_mv = 16'd3000;
  logic [15:0] eoc_mv = 16'd4200;
  logic [14:0] max_ma = 15'd1000;
  logic [15:0] fall_mv = 16'd200;
  longint      chg_mc = 3600000;
  int          soc_now = 50;
  bit          eod_set = 1'b0;
  bit          eoc_set = 1'b0;

  reading_t pending_readings[$];
  typed_t   typed_readings[$];
  row_t     dir_rows[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_arm = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  faults = 0;
  int  ticks_taken = 0;
  int  readings_checked = 0;
  int  setups_done = 0;
  int  cycle_count = 0;

  tick_t    seen_tick;
  typed_t   seen_typed;
  reading_t pred_reading;
  reading_t want_reading;
  reading_t got_reading;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic reading_t next_gauge_reading(logic signed [20:0] d, logic [15:0] vin);
    longint v, eod, eoc, mx, fl, sum, q, req, mch, mdis;
    reading_t r;
    v = vin;
    eod = eod_mv;
    eoc = eoc_mv;
    mx = max_ma;
    fl = fall_mv;
    sum = chg_mc + longint'(d);
    if (sum > CHG_MAX) sum = CHG_MAX;
    else if (sum < CHG_MIN) sum = CHG_MIN;
    chg_mc = sum;
    // EOD wins when both limits are met; a limit tick leaves the other mark alone
    if (v <= eod) begin
      chg_mc = 0;
      eod_set = 1'b1;
    end else if (v >= eoc) begin
      chg_mc = longint'(cap_mah) * SEC_PER_HOUR;
      eoc_set = 1'b1;
    end else begin
      eod_set = 1'b0;
      eoc_set = 1'b0;
    end
    if (cap_mah == 0) begin
      soc_now = 0;
    end else begin
      q = (chg_mc / MC_PER_PCT_MAH) / longint'(cap_mah);
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      soc_now = int'(q);
    end
    req = mx - (longint'(soc_now) * mx) / REQ_ZERO_SOC;
    if (req < 0) req = 0;
    else if (req > 65535) req = 65535;
    if (v >= eoc || eoc_set) mch = 0;
    else if (v <= eoc - fl) mch = mx;
    else mch = (mx * (eoc - v)) / fl;
    if (v <= eod || eod_set) mdis = 0;
    else if (v >= eod + fl) mdis = mx;
    else mdis = (mx * (v - eod)) / fl;
    r.soc_pct = soc_now[15:0];
    r.eod_flag = eod_set;
    r.eoc_flag = eoc_set;
    r.charge_req_ma = req[15:0];
    r.max_charge_ma = mch[14:0];
    r.max_discharge_ma = mdis[14:0];
    return r;
  endfunction

  function automatic reading_t reading_of(int soc, bit eod, bit eoc, int req, int mch, int mdis);
    reading_t r;
    r.soc_pct = soc[15:0];
    r.eod_flag = eod;
    r.eoc_flag = eoc;
    r.charge_req_ma = req[15:0];
    r.max_charge_ma = mch[14:0];
    r.max_discharge_ma = mdis[14:0];
    return r;
  endfunction

  function automatic row_t tick_row(int d, int v);
    row_t r;
    r.kind = ROW_TICK;
    r.addr = '0;
    r.wdata = '0;
    r.delta = d[20:0];
    r.volt = v[15:0];
    r.known = 1'b0;
    r.val = '0;
    return r;
  endfunction

  function automatic row_t known_row(int d, int v, reading_t val);
    row_t r;
    r = tick_row(d, v);
    r.known = 1'b1;
    r.val = val;
    return r;
  endfunction

  function automatic row_t reg_row(logic [2:0] a, logic [15:0] w);
    row_t r;
    r = tick_row(0, 0);
    r.kind = ROW_REG;
    r.addr = a;
    r.wdata = w;
    return r;
  endfunction

  function automatic logic [15:0] near_mv(int c, int spread);
    int x;
    x = c + int'($urandom_range(2 * spread, 0)) - spread;
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return x[15:0];
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      if (faults < REPORT_CAP)
        $error("%s: expected %0d, got %0d", field, want, got);
      faults++;
    end
  endtask

  // offer one tick, hold it until the transfer
  task automatic push_tick(logic signed [20:0] d, logic [15:0] v, bit known, reading_t val);
    typed_t t;
    t.known = known;
    t.val = val;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    typed_readings.push_back(t);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, v, d};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [15:0] w);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (a)
      REG_CAPACITY: cap_mah = w[13:0];
      REG_EOD_MV:   eod_mv = w;
      REG_EOC_MV:   eoc_mv = w;
      REG_MAX_MA:   max_ma = w[14:0];
      REG_FALLOFF:  fall_mv = w;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setup(logic [15:0] cap, logic [15:0] eod, logic [15:0] eoc,
                             logic [15:0] mx, logic [15:0] fall);
    wait_for_results();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_EOD_MV, eod);
    write_reg(REG_EOC_MV, eoc);
    write_reg(REG_MAX_MA, mx);
    write_reg(REG_FALLOFF, fall);
    write_reg(REG_SPARE_TOP, 16'($urandom()));
    setups_done++;
  endtask

  task automatic run_random(int n);
    int sel;
    int d;
    logic [15:0] v;
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(99, 0));
      if (sel < 20) v = 16'($urandom());
      else if (sel < 38) v = near_mv(int'(eod_mv), 3);
      else if (sel < 56) v = near_mv(int'(eoc_mv), 3);
      else if (sel < 66) v = near_mv(int'(eoc_mv) - int'(fall_mv), 2);
      else if (sel < 76) v = near_mv(int'(eod_mv) + int'(fall_mv), 2);
      else if (eod_mv < eoc_mv) v = 16'($urandom_range(int'(eoc_mv), int'(eod_mv)));
      else v = 16'($urandom());
      sel = int'($urandom_range(99, 0));
      if (sel < 35) d = int'($urandom());
      else if (sel < 45) d = 1048575;
      else if (sel < 55) d = -1048576;
      else if (sel < 80) d = int'($urandom_range(2000, 0)) - 1000;
      else d = int'($urandom_range(131070, 0)) - 65535;
      push_tick(d[20:0], v, 1'b0, '0);
    end
  endtask

  // runs of near-full deltas push the state of charge past its 16-bit range
  task automatic run_ramp(int n, bit down);
    int d;
    for (int i = 0; i < n; i++) begin
      d = int'($urandom_range(1048575, 1040000));
      if (down) d = -d - 1;
      push_tick(d[20:0], 16'($urandom_range(65534, 1)), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // input transfers: predict, or take the typed-in reading
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen_tick = tick_t'(in_tdata);
      pred_reading = next_gauge_reading(seen_tick.charge_delta_mc, seen_tick.batt_voltage_mv);
      seen_typed.known = 1'b0;
      if (typed_readings.size() != 0) seen_typed = typed_readings.pop_front();
      pending_readings.push_back(seen_typed.known ? seen_typed.val : pred_reading);
      ticks_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_reading = reading_t'(out_tdata);
      if (pending_readings.size() == 0) begin
        if (faults < REPORT_CAP) $error("result transfer with no reading expected");
        faults++;
      end else begin
        want_reading = pending_readings.pop_front();
        if ($isunknown(out_tdata)) begin
          if (faults < REPORT_CAP) $error("out_tdata: unknown bits %h", out_tdata);
          faults++;
        end
        check_field("soc_pct", want_reading.soc_pct, got_reading.soc_pct);
        check_field("eod_flag", want_reading.eod_flag, got_reading.eod_flag);
        check_field("eoc_flag", want_reading.eoc_flag, got_reading.eoc_flag);
        check_field("charge_req_ma", want_reading.charge_req_ma, got_reading.charge_req_ma);
        check_field("max_charge_ma", want_reading.max_charge_ma, got_reading.max_charge_ma);
        check_field("max_discharge_ma", want_reading.max_discharge_ma,
                    got_reading.max_discharge_ma);
        readings_checked++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;

    // reset defaults first, then limits, derating bands and edges
    dir_rows.push_back(known_row(0, 3600, reading_of(50, 0, 0, 0, 1000, 1000)));
    dir_rows.push_back(known_row(0, 0, reading_of(0, 1, 0, 1000, 1000, 0)));
    dir_rows.push_back(known_row(0, 65535, reading_of(100, 1, 1, 0, 0, 0)));
    dir_rows.push_back(known_row(0, 3600, reading_of(100, 0, 0, 0, 1000, 1000)));
    dir_rows.push_back(tick_row(-1048576, 3001));
    dir_rows.push_back(tick_row(1048575, 4199));
    dir_rows.push_back(tick_row(-1048576, 3100));
    dir_rows.push_back(tick_row(0, 4100));
    dir_rows.push_back(tick_row(12345, 4000));
    dir_rows.push_back(tick_row(-7, 3200));
    dir_rows.push_back(known_row(0, 3000, reading_of(0, 1, 0, 1000, 1000, 0)));
    dir_rows.push_back(tick_row(-1048576, 3500));
    dir_rows.push_back(known_row(0, 4200, reading_of(100, 0, 1, 0, 0, 1000)));
    // zero capacity via masked bits, ignored index, empty band, eod above eoc
    dir_rows.push_back(reg_row(REG_CAPACITY, 16'hC000));
    dir_rows.push_back(reg_row(REG_SPARE, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_FALLOFF, 16'd0));
    dir_rows.push_back(reg_row(REG_MAX_MA, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_EOD_MV, 16'd5000));
    dir_rows.push_back(reg_row(REG_EOC_MV, 16'd3000));
    dir_rows.push_back(tick_row(1048575, 4000));
    dir_rows.push_back(tick_row(5, 6000));
    dir_rows.push_back(tick_row(-3, 0));
    dir_rows.push_back(tick_row(100, 65535));
    dir_rows.push_back(reg_row(REG_EOD_MV, 16'd1000));
    dir_rows.push_back(reg_row(REG_EOC_MV, 16'd2000));
    dir_rows.push_back(reg_row(REG_CAPACITY, 16'd1));
    dir_rows.push_back(tick_row(1048575, 1500));
    dir_rows.push_back(tick_row(-1048576, 1999));
    dir_rows.push_back(tick_row(-1048576, 1001));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct = 82;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_for_results();
        write_reg(dir_rows[i].addr, dir_rows[i].wdata);
      end else begin
        push_tick(dir_rows[i].delta, dir_rows[i].volt, dir_rows[i].known, dir_rows[i].val);
      end
    end

    apply_setup(16'd2000, 16'd3000, 16'd4200, 16'd1000, 16'd200);
    run_random(200);
    hold_arm = 1'b1;     // output held off while ticks keep coming
    run_random(150);
    wait_for_results();
    run_random(150);

    send_idle_pct = 82;
    recv_idle_pct = 6;
    apply_setup(16'hFFFF, 16'd1000, 16'd60000, 16'd20000, 16'd1);
    run_random(300);
    apply_setup(16'd2500, 16'd2800, 16'd4350, 16'd3000, 16'd150);
    run_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setup(16'd0, 16'd5000, 16'd3000, 16'd1500, 16'd300);
    run_random(150);
    apply_setup(16'd500, 16'd3300, 16'd4100, 16'd0, 16'd0);
    run_random(150);
    apply_setup(16'd1, 16'd0, 16'd65535, 16'hFFFF, 16'd65535);
    push_tick(21'sd0, 16'd65535, 1'b0, '0);
    run_ramp(40, 1'b0);
    push_tick(21'sd0, 16'd0, 1'b0, '0);
    run_ramp(40, 1'b1);
    run_random(100);

    wait_for_results();
    $display("summary: %0d ticks over %0d register setups, %0d readings checked",
             ticks_taken, setups_done, readings_checked);
    $display("summary: voltage limits, derating bands, zero capacity and falloff, saturation");
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bcg_pkg.sv
src/bcg_div.sv
src/battery_charge_gauge.sv
verif/battery_charge_gauge_test.sv
